// File: rtl/scp_pkg.sv
// Shared types and constants for the skyline contour placement block.
// Used by the controller, the datapath, the top level and the checker.
package scp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int HEIGHT_BITS   = 20;
  localparam int BLOCK_H_BITS  = 16;
  localparam int BASE_Y_BITS   = 20;
  localparam int STATUS_BITS   = 2;
  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_SAT   = 2'd3;

  // Write slot within one segment step.
  typedef enum logic [1:0] {
    PH_NONE,
    PH_LEFT,
    PH_NEW,
    PH_RIGHT
  } phase_t;

  typedef struct packed {
    logic   capture;
    logic   do_clear;
    logic   res_empty;
    logic   rd_first;
    logic   load_cur;
    logic   rd_next;
    logic   latch_end;
    logic   set_tail;
    logic   inc_i;
    phase_t ph;
    logic   commit;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic empty_span;
    logic more;
  } sts_t;

endpackage

// File: rtl/skyline_contour_place_core.sv
// Top level of the skyline contour placement block.
// Depends on scp_pkg, scp_ctrl and scp_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per request: op, span_start,
//   span_end, block_height. op 0 flattens the contour to one segment at height 0;
//   op 1 drops a block on [span_start, span_end) and rewrites that span at
//   base_y + block_height.
//   Output channel (out_valid/out_ready) returns one beat per request: base_y and
//   status (ok, table full, empty span, height saturated).
// Sequencing:
//   Clear and empty-span requests are answered from the decode state without
//   reading the table. A placement walks the live table one segment per step
//   through a single memory read port: each segment takes a read, an end fetch
//   and three write slots, and the last segment skips the end fetch; a final
//   commit step then patches the new segment and writes the result.
//   A new request is taken once the previous one has been turned into a result.
// Reset:
//   The contour comes up as one flat segment at height 0; no sweep is needed.
// Stall:
//   A finished result sits in the output register; the block accepts the next
//   request meanwhile and holds before writing the next result until it drains.
module skyline_contour_place_core #(
  parameter int MAX_SEGMENTS = scp_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [scp_pkg::COORD_BITS-1:0]   span_start,
  input  logic [scp_pkg::COORD_BITS-1:0]   span_end,
  input  logic [scp_pkg::BLOCK_H_BITS-1:0] block_height,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scp_pkg::BASE_Y_BITS-1:0]  base_y,
  output logic [scp_pkg::STATUS_BITS-1:0]  status
);

  scp_pkg::cmd_t cmd;
  scp_pkg::sts_t sts;

  // sequencer
  scp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, scan registers and result register
  scp_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .span_start   (span_start),
    .span_end     (span_end),
    .block_height (block_height),
    .base_y       (base_y),
    .status       (status)
  );

endmodule

// File: rtl/scp_datapath.sv
// Datapath: input capture, ping-pong segment table, scan registers, result register.
// Depends on scp_pkg; driven by scp_ctrl through scp_pkg::cmd_t.
module scp_datapath #(
  parameter int MAX_SEGMENTS = scp_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  scp_pkg::cmd_t                       cmd,
  output scp_pkg::sts_t                       sts,
  input  logic                                op,
  input  logic [scp_pkg::COORD_BITS-1:0]      span_start,
  input  logic [scp_pkg::COORD_BITS-1:0]      span_end,
  input  logic [scp_pkg::BLOCK_H_BITS-1:0]    block_height,
  output logic [scp_pkg::BASE_Y_BITS-1:0]     base_y,
  output logic [scp_pkg::STATUS_BITS-1:0]     status
);

  localparam int CW    = scp_pkg::COORD_BITS;
  localparam int HW    = scp_pkg::HEIGHT_BITS;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int WP_W  = $clog2(MAX_SEGMENTS + 3);
  localparam int ENT_W = CW + HW;

  // Two banks: read the live one, build the new contour in the other.
  // The bank bit sits above the index, so each bank spans a power of two.
  logic [ENT_W-1:0] mem [2**(IDX_W+1)];

  logic              opq;
  logic [CW-1:0]     x1, x2;
  logic [scp_pkg::BLOCK_H_BITS-1:0] hgt;
  logic              bank;
  logic              fresh;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  i;
  logic [WP_W-1:0]   wp;
  logic [IDX_W-1:0]  fix_idx;
  logic              placed;
  logic [HW-1:0]     base;
  logic [CW-1:0]     cs;
  logic [HW-1:0]     cy;
  logic [CW:0]       e;
  logic [ENT_W-1:0]  rd_q;
  logic              rd_zero;

  logic [CNT_W:0]    i_plus1;
  logic              rd_en;
  logic [IDX_W:0]    raddr;
  logic [CW-1:0]     rd_s;
  logic [HW-1:0]     rd_y;
  logic [CW:0]       x1e, x2e;
  logic              full;
  logic [HW:0]       sum;
  logic              sat;
  logic [HW-1:0]     top;
  logic              push_en;
  logic [CW-1:0]     push_s;
  logic [HW-1:0]     push_y;
  logic              we;
  logic [IDX_W:0]    waddr;
  logic [ENT_W-1:0]  wdata;

  assign i_plus1 = {1'b0, i} + (CNT_W+1)'(1);
  assign rd_en   = cmd.rd_first | cmd.rd_next;
  assign raddr   = {bank, (cmd.rd_first ? IDX_W'(0) : i_plus1[IDX_W-1:0])};
  assign rd_s    = rd_zero ? '0 : rd_q[ENT_W-1:HW];
  assign rd_y    = rd_zero ? '0 : rd_q[HW-1:0];
  assign x1e     = {1'b0, x1};
  assign x2e     = {1'b0, x2};
  assign full    = wp > WP_W'(MAX_SEGMENTS);
  assign sum     = {1'b0, base} + (HW+1)'(hgt);
  assign sat     = sum[HW];
  assign top     = sat ? '1 : sum[HW-1:0];

  assign sts.is_clear   = ~opq;
  assign sts.empty_span = x2 <= x1;
  assign sts.more       = i_plus1 < {1'b0, cnt};

  always_comb begin
    push_en = 1'b0;
    push_s  = cs;
    push_y  = cy;
    case (cmd.ph)
      scp_pkg::PH_LEFT:  push_en = (e <= x1e) || (cs < x1);
      scp_pkg::PH_NEW: begin
        push_en = (e > x1e) && !placed;
        push_s  = x1;
        push_y  = '0;
      end
      scp_pkg::PH_RIGHT: begin
        push_en = (e > x1e) && (e > x2e);
        push_s  = (cs > x2) ? cs : x2;
      end
      default: push_en = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (push_en && (wp < WP_W'(MAX_SEGMENTS))) begin
      we    = 1'b1;
      waddr = {~bank, wp[IDX_W-1:0]};
      wdata = {push_s, push_y};
    end
    if (cmd.do_clear) begin
      we    = 1'b1;
      waddr = {~bank, IDX_W'(0)};
      wdata = '0;
    end
    if (cmd.commit && !full) begin
      // patch the new segment height once the base is known
      we    = 1'b1;
      waddr = {~bank, fix_idx};
      wdata = {x1, top};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q    <= mem[raddr];
      rd_zero <= fresh;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      fresh <= 1'b1;
      cnt   <= CNT_W'(1);
    end else if (cmd.do_clear) begin
      bank  <= ~bank;
      fresh <= 1'b0;
      cnt   <= CNT_W'(1);
    end else if (cmd.commit && !full) begin
      bank  <= ~bank;
      fresh <= 1'b0;
      cnt   <= wp[CNT_W-1:0];
    end
  end

  // scan and payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opq <= op;
      x1  <= span_start;
      x2  <= span_end;
      hgt <= block_height;
    end
    if (cmd.rd_first) begin
      i      <= '0;
      wp     <= '0;
      placed <= 1'b0;
      base   <= '0;
    end
    if (cmd.inc_i) begin
      i <= i_plus1[CNT_W-1:0];
    end
    if (cmd.load_cur) begin
      cs <= rd_s;
      cy <= rd_y;
    end
    if (cmd.latch_end) begin
      e <= {1'b0, rd_s};
    end
    if (cmd.set_tail) begin
      e <= {1'b1, CW'(0)};
    end
    if (cmd.ph == scp_pkg::PH_LEFT && cs < x2 && e > x1e && cy > base) begin
      base <= cy;
    end
    if (cmd.ph == scp_pkg::PH_NEW && push_en) begin
      fix_idx <= wp[IDX_W-1:0];
      placed  <= 1'b1;
    end
    if (push_en) begin
      wp <= wp + WP_W'(1);
    end
    if (cmd.do_clear) begin
      base_y <= '0;
      status <= scp_pkg::ST_OK;
    end else if (cmd.res_empty) begin
      base_y <= '0;
      status <= scp_pkg::ST_EMPTY;
    end else if (cmd.commit) begin
      base_y <= full ? '0 : base;
      status <= full ? scp_pkg::ST_FULL : (sat ? scp_pkg::ST_SAT : scp_pkg::ST_OK);
    end
  end

endmodule

// File: rtl/scp_ctrl.sv
// Controller: sequences capture, the segment walk, the commit and the output beat.
// Depends on scp_pkg; drives scp_datapath through scp_pkg::cmd_t.
module scp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  scp_pkg::sts_t sts,
  output scp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_NEXT   = 4'd3;
  localparam logic [3:0] S_PH0    = 4'd4;
  localparam logic [3:0] S_PH1    = 4'd5;
  localparam logic [3:0] S_PH2    = 4'd6;
  localparam logic [3:0] S_FIX    = 4'd7;

  logic [3:0] state, state_next;
  logic       can_emit;
  logic       emit;

  assign in_ready = (state == S_IDLE);
  assign can_emit = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    cmd.ph     = scp_pkg::PH_NONE;
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_clear) begin
          if (can_emit) begin
            cmd.do_clear = 1'b1;
            emit         = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (sts.empty_span) begin
          if (can_emit) begin
            cmd.res_empty = 1'b1;
            emit          = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_cur = 1'b1;
        if (sts.more) begin
          cmd.rd_next = 1'b1;
          state_next  = S_NEXT;
        end else begin
          cmd.set_tail = 1'b1;
          state_next   = S_PH0;
        end
      end
      S_NEXT: begin
        cmd.latch_end = 1'b1;
        state_next    = S_PH0;
      end
      S_PH0: begin
        cmd.ph     = scp_pkg::PH_LEFT;
        state_next = S_PH1;
      end
      S_PH1: begin
        cmd.ph     = scp_pkg::PH_NEW;
        state_next = S_PH2;
      end
      S_PH2: begin
        cmd.ph = scp_pkg::PH_RIGHT;
        if (sts.more) begin
          cmd.inc_i  = 1'b1;
          state_next = S_LOAD;
        end else begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        if (can_emit) begin
          cmd.commit = 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/scp_checker.sv
// Port-level checks for skyline_contour_place_core, attached by bind.
// Depends on scp_pkg.
module scp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [scp_pkg::BASE_Y_BITS-1:0]  base_y,
  input logic [scp_pkg::STATUS_BITS-1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(base_y) && $stable(status))
    else $error("output beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before the first was processed");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == scp_pkg::ST_FULL || status == scp_pkg::ST_EMPTY) |-> base_y == '0)
    else $error("rejected request reports a nonzero base");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind skyline_contour_place_core scp_checker u_scp_checker (.*);
